[design/assert_macros.svh]
// assertion macros shared by the scheduler rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dlts_pkg.sv]
// shared types and action codes of the delta list task scheduler
// no dependencies; used by dlts_mem and the top level
`timescale 1ns / 1ps

package dlts_pkg;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_ADD  = 2'd1;
  localparam logic [1:0] ACT_DEL  = 2'd2;
  localparam logic [1:0] ACT_DSP  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] task_handle;
    logic [23:0] start_delay;
    logic [23:0] repeat_period;
    logic [31:0] target_id;
  } cmd_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] out_handle;
    logic [31:0] out_id;
    logic [31:0] reissue_id;
  } res_t;

  // one timer list slot
  typedef struct packed {
    logic [15:0] handle;
    logic [23:0] delta;
    logic [23:0] period;
    logic [31:0] ident;
    logic        due;
  } entry_t;

endpackage

[design/dlts_mem.sv]
// timer list entry memory: one write port, one registered read port
// depends on dlts_pkg for the entry type
`timescale 1ns / 1ps

module dlts_mem import dlts_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // write-first forwarding when both ports hit the same slot
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/delta_list_task_scheduler_unit.sv]
// Delta list task scheduler, top level; uses dlts_pkg, dlts_mem and assert_macros.svh.
// A command is taken when start is high and busy is low; its single result appears on
// out_item for exactly one cycle with out_valid high and cannot be held off by the
// receiver. Tasks live in one entry memory, kept as a compact sorted list with a fill
// count, so no clearing pass is needed after reset. Every list walk moves one entry per
// cycle through the memory's single read port. A rejected command or a tick on an empty
// list is answered from the idle state itself; a dispatch of a periodic task is a delete
// followed by an add. busy falls in the cycle the result strobe is shown.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delta_list_task_scheduler_unit import dlts_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  cmd_t in_item,
  output logic out_valid,
  output res_t out_item
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_C   = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] ADDR_ONE = AW'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_ADD_START,
    ST_ADD_SCAN,
    ST_ADD_PRIME,
    ST_ADD_SHW,
    ST_ADD_INS,
    ST_DEL_SCAN,
    ST_DSP_RD,
    ST_DEL_SHW
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   idc_r, idc_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [23:0]   sum_r, sum_nxt;
  logic [23:0]   fold_r, fold_nxt;
  logic [23:0]   nd_r, nd_nxt;
  logic [31:0]   dsp_id_r, dsp_id_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_item_r, out_item_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        ent;

  logic [CW-1:0] idx_p1, idx_p2, idx_m1, idx_m2, pos_p1;
  logic [24:0]   sum_ext, fold_diff;
  logic          past;
  logic [31:0]   id_inc, id_next;
  logic          del_done, rsp_en;
  res_t          rsp;

  dlts_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  assign idx_p1    = idx_r + CW'(1);
  assign idx_p2    = idx_r + CW'(2);
  assign idx_m1    = idx_r - CW'(1);
  assign idx_m2    = idx_r - CW'(2);
  assign pos_p1    = pos_r + CW'(1);
  assign sum_ext   = {1'b0, sum_r} + {1'b0, ent.delta};
  assign fold_diff = sum_ext - {1'b0, cmd_r.start_delay};
  assign past      = sum_ext > {1'b0, cmd_r.start_delay};
  assign id_inc    = idc_r + 32'd1;
  assign id_next   = (id_inc == 32'd0) ? 32'd1 : id_inc;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idc_nxt       = idc_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    fold_nxt      = fold_r;
    nd_nxt        = nd_r;
    dsp_id_nxt    = dsp_id_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = ent;
    mem_raddr     = '0;
    del_done      = 1'b0;
    rsp_en        = 1'b0;
    rsp           = '0;

    case (state_r)
      ST_IDLE: begin
        mem_raddr = '0;
        if (start) begin
          cmd_nxt = in_item;
          idx_nxt = '0;
          sum_nxt = '0;
          case (in_item.action)
            ACT_TICK: begin
              if (cnt_r == '0) begin
                rsp_en = 1'b1;
                rsp.ok = 1'b1;
              end else begin
                state_nxt = ST_TICK;
              end
            end
            ACT_ADD: begin
              if (in_item.task_handle == '0 || cnt_r == FULL_C) begin
                rsp_en = 1'b1;
              end else begin
                state_nxt = ST_ADD_SCAN;
              end
            end
            ACT_DEL: begin
              if (in_item.target_id == '0 || cnt_r == '0) begin
                rsp_en = 1'b1;
              end else begin
                state_nxt = ST_DEL_SCAN;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                rsp_en = 1'b1;
              end else begin
                state_nxt = ST_DSP_RD;
              end
            end
          endcase
        end
      end

      ST_TICK: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        if (!ent.due) begin
          if (ent.delta != '0) begin
            mem_wdata.delta = ent.delta - 24'd1;
          end
          if (mem_wdata.delta == '0) begin
            mem_wdata.due = 1'b1;
          end
        end
        rsp_en = 1'b1;
        rsp.ok = 1'b1;
      end

      ST_ADD_START: begin
        mem_raddr = '0;
        idx_nxt   = '0;
        sum_nxt   = '0;
        state_nxt = ST_ADD_SCAN;
      end

      // running sum of deltas; read of the following slot is already in flight
      ST_ADD_SCAN: begin
        mem_raddr = idx_p1[AW-1:0];
        if (idx_r == cnt_r) begin
          nd_nxt    = cmd_r.start_delay - sum_r;
          pos_nxt   = idx_r;
          state_nxt = ST_ADD_INS;
        end else if (past) begin
          nd_nxt    = cmd_r.start_delay - sum_r;
          fold_nxt  = fold_diff[23:0];
          pos_nxt   = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = ST_ADD_PRIME;
        end else begin
          sum_nxt = sum_ext[23:0];
          idx_nxt = idx_p1;
        end
      end

      ST_ADD_PRIME: begin
        mem_raddr = idx_m1[AW-1:0];
        state_nxt = ST_ADD_SHW;
      end

      // shift up from the tail, the displaced entry gets its shortened delta
      ST_ADD_SHW: begin
        mem_raddr = idx_m2[AW-1:0];
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        if (idx_r == pos_p1) begin
          mem_wdata.delta = fold_r;
          state_nxt       = ST_ADD_INS;
        end else begin
          idx_nxt = idx_m1;
        end
      end

      ST_ADD_INS: begin
        mem_we           = 1'b1;
        mem_waddr        = pos_r[AW-1:0];
        mem_wdata.handle = cmd_r.task_handle;
        mem_wdata.delta  = nd_r;
        mem_wdata.period = cmd_r.repeat_period;
        mem_wdata.ident  = id_next;
        mem_wdata.due    = (nd_r == '0);
        idc_nxt          = id_next;
        cnt_nxt          = cnt_r + CW'(1);
        rsp_en           = 1'b1;
        rsp.ok           = 1'b1;
        if (cmd_r.action == ACT_DSP) begin
          rsp.out_handle = cmd_r.task_handle;
          rsp.out_id     = dsp_id_r;
          rsp.reissue_id = id_next;
        end else begin
          rsp.out_id = id_next;
        end
      end

      ST_DEL_SCAN: begin
        mem_raddr = idx_p1[AW-1:0];
        if (ent.ident == cmd_r.target_id) begin
          pos_nxt  = idx_r;
          fold_nxt = ent.delta;
          if (idx_p1 == cnt_r) begin
            del_done = 1'b1;
          end else begin
            state_nxt = ST_DEL_SHW;
          end
        end else if (idx_p1 == cnt_r) begin
          rsp_en = 1'b1;
        end else begin
          idx_nxt = idx_p1;
        end
      end

      // a due head is removed like a delete, then re-added when periodic
      ST_DSP_RD: begin
        mem_raddr = ADDR_ONE;
        if (!ent.due) begin
          rsp_en = 1'b1;
        end else begin
          cmd_nxt.task_handle   = ent.handle;
          cmd_nxt.start_delay   = ent.period;
          cmd_nxt.repeat_period = ent.period;
          dsp_id_nxt            = ent.ident;
          pos_nxt               = '0;
          idx_nxt               = '0;
          fold_nxt              = ent.delta;
          if (cnt_r == CW'(1)) begin
            del_done = 1'b1;
          end else begin
            state_nxt = ST_DEL_SHW;
          end
        end
      end

      // shift down over the removed slot, first moved entry absorbs its delta
      ST_DEL_SHW: begin
        mem_raddr = idx_p2[AW-1:0];
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        if (idx_r == pos_r) begin
          mem_wdata.delta = ent.delta + fold_r;
        end
        if (idx_p2 == cnt_r) begin
          del_done = 1'b1;
        end else begin
          idx_nxt = idx_p1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (del_done) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cmd_r.action == ACT_DSP && cmd_nxt.repeat_period != '0) begin
        state_nxt = ST_ADD_START;
      end else begin
        rsp_en = 1'b1;
        rsp.ok = 1'b1;
        if (cmd_r.action == ACT_DSP) begin
          rsp.out_handle = cmd_nxt.task_handle;
          rsp.out_id     = dsp_id_nxt;
        end
      end
    end

    if (rsp_en) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = rsp;
      state_nxt     = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      fold_r      <= fold_nxt;
      nd_r        <= nd_nxt;
      dsp_id_r    <= dsp_id_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CHK_ALWAYS(a_cnt_range, cnt_r <= FULL_C, "fill count beyond table depth")
  `CHK_NEXT(a_accept_progress, start && !busy, busy || out_valid,
            "command neither run nor answered")
  `CHK_IMPL(a_fail_zero, out_valid && !out_item.ok,
            out_item.out_handle == '0 && out_item.out_id == '0 && out_item.reissue_id == '0,
            "failed transaction carries data")
  `CHK_IMPL(a_write_busy, mem_we, busy, "entry memory written while idle")
  `CHK_IMPL(a_id_nonzero, idc_r != $past(idc_r), idc_r != '0, "id counter stepped to zero")

endmodule
